/* rtl/htpf_pkg.sv */
// Shared types and codes for the handle table with ring-buffer pipes.
package htpf_pkg;

  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_CLOSE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PERM  = 2'd1,
    ST_NORES = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PERM_NIL = 2'd0,
    PERM_RD  = 2'd1,
    PERM_WR  = 2'd2
  } perm_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MEM,
    S_DONE
  } state_t;

endpackage

/* rtl/handle_table_pipe_fifos_core.sv */
// Top level: handle table and ring-buffer pipe pool behind a request/result stream.
//
// One request at a time. Write, read and close go through the memory-access
// state to the result; open scans one handle and one buffer per cycle, side by
// side with separate compares, then goes through a decide state to the
// result. The byte store is one memory with a registered read
// port; its read is issued in the memory-access cycle and lands in time for the
// result, so reads take no longer than writes. The result sits in an output
// register and the next request is taken once it has been delivered.
module handle_table_pipe_fifos_core #(
  parameter int NUM_HANDLES = 16,
  parameter int PIPE_BYTES  = 64,
  parameter int NUM_BUFFERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // op[1:0], handle[5:2], data_in[13:6], zero pad
  input  logic        s_tlast,   // transfer_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // status[1:0], read_handle[5:2], write_handle[9:6],
                                 // data_out[17:10], zero pad
  output logic        m_tlast    // transfer_end_echo
);

  localparam int HW   = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;
  localparam int BW   = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int PW   = $clog2(PIPE_BYTES);
  localparam int FW   = $clog2(PIPE_BYTES + 1);
  localparam int SCAN = (NUM_HANDLES > NUM_BUFFERS) ? NUM_HANDLES : NUM_BUFFERS;
  localparam int CW   = $clog2(SCAN + 1);
  localparam int AW   = BW + PW;

  // handle table and buffer descriptors
  logic                slot_in_use [NUM_HANDLES];
  htpf_pkg::perm_t     slot_perm   [NUM_HANDLES];
  logic [BW-1:0]       slot_buffer [NUM_HANDLES];
  logic [HW-1:0]       search_start;
  logic [1:0]          buffer_refs [NUM_BUFFERS];
  logic [PW-1:0]       buffer_head [NUM_BUFFERS];
  logic [PW-1:0]       buffer_tail [NUM_BUFFERS];
  logic [FW-1:0]       buffer_fill [NUM_BUFFERS];

  // request registers
  htpf_pkg::op_t       op;
  logic [3:0]          handle;
  logic [7:0]          data_in;
  logic                tend;

  // scan state
  logic [CW-1:0]       cnt;
  logic [HW-1:0]       hidx;
  logic                r_found, w_found, b_found;
  logic [HW-1:0]       r_slot, w_slot;
  logic [BW-1:0]       b_sel;
  logic [BW-1:0]       bidx;

  htpf_pkg::state_t    state, state_next;
  htpf_pkg::status_t   res_status;
  logic [3:0]          res_rh, res_wh;
  logic                rd_pending;
  logic [7:0]          rdata;

  logic                ram_we;
  logic                ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;

  logic                h_ok;
  logic [HW-1:0]       hs;
  logic [BW-1:0]       hb;

  assign h_ok = ({28'd0, handle} < 32'(NUM_HANDLES));
  assign hs   = HW'(handle);
  assign hb   = slot_buffer[hs];

  htpf_byte_ram #(.DEPTH(NUM_BUFFERS * (2 ** PW)), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (data_in),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  assign ram_waddr = {hb, buffer_tail[hb]};
  assign ram_raddr = {hb, buffer_head[hb]};
  assign ram_re    = (state == htpf_pkg::S_MEM);

  assign s_tready = (state == htpf_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= htpf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      htpf_pkg::S_IDLE:   if (s_tvalid) begin
        state_next = (htpf_pkg::op_t'(s_tdata[1:0]) == htpf_pkg::OP_OPEN) ?
                     htpf_pkg::S_SCAN : htpf_pkg::S_MEM;
      end
      htpf_pkg::S_SCAN:   if (cnt == CW'(SCAN - 1)) begin
        state_next = htpf_pkg::S_DECIDE;
      end
      htpf_pkg::S_DECIDE: state_next = htpf_pkg::S_DONE;
      htpf_pkg::S_MEM:    state_next = htpf_pkg::S_DONE;
      htpf_pkg::S_DONE:   if (m_tready) begin
        state_next = htpf_pkg::S_IDLE;
      end
      default:            state_next = htpf_pkg::S_IDLE;
    endcase
  end

  // memory write on a successful byte write
  always_comb begin
    ram_we = 1'b0;
    if (state == htpf_pkg::S_MEM && op == htpf_pkg::OP_WRITE && h_ok &&
        slot_in_use[hs] && slot_perm[hs] == htpf_pkg::PERM_WR &&
        buffer_fill[hb] != FW'(PIPE_BYTES)) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_HANDLES; i++) begin
        slot_in_use[i] <= 1'b0;
        slot_perm[i]   <= htpf_pkg::PERM_NIL;
        slot_buffer[i] <= '0;
      end
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        buffer_refs[i] <= '0;
        buffer_head[i] <= '0;
        buffer_tail[i] <= '0;
        buffer_fill[i] <= '0;
      end
      search_start <= '0;
      rd_pending   <= 1'b0;
    end else begin
      unique case (state)
        htpf_pkg::S_IDLE: begin
          if (s_tvalid) begin
            op      <= htpf_pkg::op_t'(s_tdata[1:0]);
            handle  <= s_tdata[5:2];
            data_in <= s_tdata[13:6];
            tend    <= s_tlast;
            cnt     <= '0;
            hidx    <= search_start;
            bidx    <= '0;
            r_found <= 1'b0;
            w_found <= 1'b0;
            b_found <= 1'b0;
          end
        end
        htpf_pkg::S_SCAN: begin
          // one handle and one buffer per cycle
          cnt <= cnt + 1'b1;
          if (cnt < CW'(NUM_HANDLES)) begin
            if (!slot_in_use[hidx] && !w_found) begin
              if (!r_found) begin
                r_found <= 1'b1;
                r_slot  <= hidx;
              end else begin
                w_found <= 1'b1;
                w_slot  <= hidx;
              end
            end
            hidx <= (hidx == HW'(NUM_HANDLES - 1)) ? '0 : hidx + 1'b1;
          end
          if (cnt < CW'(NUM_BUFFERS)) begin
            if (buffer_refs[bidx] == 2'd0 && !b_found) begin
              b_found <= 1'b1;
              b_sel   <= bidx;
            end
            if (bidx != BW'(NUM_BUFFERS - 1)) begin
              bidx <= bidx + 1'b1;
            end
          end
        end
        htpf_pkg::S_DECIDE: begin
          rd_pending <= 1'b0;
          if (r_found && w_found && b_found) begin
            res_status          <= htpf_pkg::ST_OK;
            res_rh              <= 4'(r_slot);
            res_wh              <= 4'(w_slot);
            buffer_refs[b_sel]  <= 2'd2;
            buffer_head[b_sel]  <= '0;
            buffer_tail[b_sel]  <= '0;
            buffer_fill[b_sel]  <= '0;
            slot_in_use[r_slot] <= 1'b1;
            slot_perm[r_slot]   <= htpf_pkg::PERM_RD;
            slot_buffer[r_slot] <= b_sel;
            slot_in_use[w_slot] <= 1'b1;
            slot_perm[w_slot]   <= htpf_pkg::PERM_WR;
            slot_buffer[w_slot] <= b_sel;
            search_start <= (w_slot == HW'(NUM_HANDLES - 1)) ? '0 : w_slot + 1'b1;
          end else begin
            res_status <= htpf_pkg::ST_NORES;
            res_rh     <= '0;
            res_wh     <= '0;
          end
        end
        htpf_pkg::S_MEM: begin
          res_rh <= '0;
          res_wh <= '0;
          if (!h_ok) begin
            res_status <= htpf_pkg::ST_PERM;
            rd_pending <= 1'b0;
          end else if (op == htpf_pkg::OP_CLOSE) begin
            res_status <= htpf_pkg::ST_OK;
            rd_pending <= 1'b0;
            if (slot_in_use[hs]) begin
              if (buffer_refs[hb] != 2'd0) begin
                buffer_refs[hb] <= buffer_refs[hb] - 1'b1;
              end
              slot_in_use[hs] <= 1'b0;
              slot_perm[hs]   <= htpf_pkg::PERM_NIL;
              slot_buffer[hs] <= '0;
            end
          end else if (!slot_in_use[hs] ||
                       (op == htpf_pkg::OP_WRITE && slot_perm[hs] != htpf_pkg::PERM_WR) ||
                       (op == htpf_pkg::OP_READ && slot_perm[hs] != htpf_pkg::PERM_RD)) begin
            res_status <= htpf_pkg::ST_PERM;
            rd_pending <= 1'b0;
          end else if (op == htpf_pkg::OP_WRITE) begin
            rd_pending <= 1'b0;
            if (buffer_fill[hb] == FW'(PIPE_BYTES)) begin
              res_status <= htpf_pkg::ST_FULL;
            end else begin
              res_status      <= htpf_pkg::ST_OK;
              buffer_tail[hb] <= (buffer_tail[hb] == PW'(PIPE_BYTES - 1)) ?
                                 '0 : buffer_tail[hb] + 1'b1;
              buffer_fill[hb] <= buffer_fill[hb] + 1'b1;
            end
          end else begin
            if (buffer_fill[hb] == '0) begin
              res_status <= htpf_pkg::ST_FULL;
              rd_pending <= 1'b0;
            end else begin
              res_status      <= htpf_pkg::ST_OK;
              rd_pending      <= 1'b1;
              buffer_head[hb] <= (buffer_head[hb] == PW'(PIPE_BYTES - 1)) ?
                                 '0 : buffer_head[hb] + 1'b1;
              buffer_fill[hb] <= buffer_fill[hb] - 1'b1;
            end
          end
        end
        htpf_pkg::S_DONE: ;
        default: ;
      endcase
    end
  end

  assign m_tvalid = (state == htpf_pkg::S_DONE);
  assign m_tdata  = {6'd0, (rd_pending ? rdata : 8'd0), res_wh, res_rh, res_status};
  assign m_tlast  = tend;

endmodule

/* rtl/htpf_byte_ram.sv */
// Byte storage for all pipe buffers, one write and one registered read port.
module htpf_byte_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold the last byte read until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* tb/sv/pipe_table_checker.sv */
// Result checker: mirrors the handle table and pipe pool and compares every result.
`timescale 1ns / 100ps
module pipe_table_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending
);
  localparam int NH = 16;
  localparam int NB = 16;
  localparam int PB = 64;

  typedef struct packed {
    logic              tend;
    logic [7:0]        dout;
    logic [3:0]        wh;
    logic [3:0]        rh;
    htpf_pkg::status_t status;
  } pipe_result_t;

  logic              in_use [NH];
  htpf_pkg::perm_t   perm   [NH];
  logic [3:0]        buf_of [NH];
  logic [3:0]        scan_ptr;
  logic [1:0]        refs   [NB];
  logic [5:0]        head   [NB];
  logic [5:0]        tail   [NB];
  logic [6:0]        fill   [NB];
  logic [7:0]        bytes  [NB][PB];
  pipe_result_t      expected_results[$];

  assign pending = expected_results.size();

  function automatic int free_slot(int start, int skip);
    int idx;
    for (int k = 0; k < NH; k++) begin
      idx = (start + k) % NH;
      if (idx != skip && !in_use[idx]) return idx;
    end
    return NH;
  endfunction

  function automatic pipe_result_t apply_request(htpf_pkg::op_t op, logic [3:0] h,
                                                 logic [7:0] din, logic tend);
    pipe_result_t r;
    int b, rd, wr;
    logic [3:0] bb;
    r = '0;
    r.tend = tend;
    r.status = htpf_pkg::ST_OK;
    unique case (op)
      htpf_pkg::OP_OPEN: begin
        b = NB;
        for (int i = NB - 1; i >= 0; i--) if (refs[i] == 2'd0) b = i;
        rd = free_slot(int'(scan_ptr), NH);
        wr = (rd < NH) ? free_slot((rd + 1) % NH, rd) : NH;
        if (b >= NB || rd >= NH || wr >= NH) begin
          r.status = htpf_pkg::ST_NORES;
        end else begin
          refs[b] = 2'd2; head[b] = '0; tail[b] = '0; fill[b] = '0;
          in_use[rd] = 1'b1; perm[rd] = htpf_pkg::PERM_RD; buf_of[rd] = 4'(b);
          in_use[wr] = 1'b1; perm[wr] = htpf_pkg::PERM_WR; buf_of[wr] = 4'(b);
          scan_ptr = 4'((wr + 1) % NH);
          r.rh = 4'(rd);
          r.wh = 4'(wr);
        end
      end
      htpf_pkg::OP_CLOSE: begin
        if (in_use[h]) begin
          if (refs[buf_of[h]] > 2'd0) refs[buf_of[h]]--;
          in_use[h] = 1'b0; perm[h] = htpf_pkg::PERM_NIL; buf_of[h] = '0;
        end
      end
      default: begin
        bb = buf_of[h];
        if (!in_use[h] ||
            perm[h] != ((op == htpf_pkg::OP_WRITE) ? htpf_pkg::PERM_WR : htpf_pkg::PERM_RD)) begin
          r.status = htpf_pkg::ST_PERM;
        end else if (op == htpf_pkg::OP_WRITE) begin
          if (fill[bb] >= 7'(PB)) r.status = htpf_pkg::ST_FULL;
          else begin
            bytes[bb][tail[bb]] = din;
            tail[bb]++;
            fill[bb]++;
          end
        end else begin
          if (fill[bb] == '0) r.status = htpf_pkg::ST_FULL;
          else begin
            r.dout = bytes[bb][head[bb]];
            head[bb]++;
            fill[bb]--;
          end
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    pipe_result_t got, want;
    if (rst) begin
      for (int i = 0; i < NH; i++) begin
        in_use[i] = 1'b0; perm[i] = htpf_pkg::PERM_NIL; buf_of[i] = '0;
      end
      for (int i = 0; i < NB; i++) begin
        refs[i] = '0; head[i] = '0; tail[i] = '0; fill[i] = '0;
      end
      scan_ptr = '0;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      // check before predicting: a result never comes from a request taken this edge
      if (m_tvalid && m_tready) begin
        got = {m_tlast, m_tdata[17:10], m_tdata[9:6], m_tdata[5:2], m_tdata[1:0]};
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: %h", m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got != want) fail_count <= fail_count + 1;
          if (got.status != want.status)
            $error("status expected %0d got %0d", want.status, got.status);
          if (got.rh != want.rh)
            $error("read_handle expected %0d got %0d", want.rh, got.rh);
          if (got.wh != want.wh)
            $error("write_handle expected %0d got %0d", want.wh, got.wh);
          if (got.dout != want.dout)
            $error("data_out expected %0d got %0d", want.dout, got.dout);
          if (got.tend != want.tend)
            $error("transfer_end_echo expected %0d got %0d", want.tend, got.tend);
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(apply_request(htpf_pkg::op_t'(s_tdata[1:0]),
                                                 s_tdata[5:2], s_tdata[13:6], s_tlast));
    end
  end
endmodule

/* tb/sv/handle_table_pipe_fifos_core_tb.sv */
// Testbench top: drives pipe requests and random back-pressure, reports the verdict.
`timescale 1ns / 100ps
module handle_table_pipe_fifos_core_tb;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  int          fail_count;
  int          pending;
  logic        stall_done = 0;
  int          sent = 0;
  logic [3:0]  open_handles[$];

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  handle_table_pipe_fifos_core DUT (.*);

  pipe_table_checker checker_i (.*);

  // receiver: random stall per result, one long hold-off partway in
  initial begin
    int wait_n;
    @(posedge clk iff !rst);
    forever begin
      if (sent > 200 && !stall_done) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        stall_done = 1;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (wait_n > 0) begin
        m_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk iff m_tvalid);
    end
  end

  // keep tvalid up between back-to-back requests; drop it only for a gap
  task automatic send_request(htpf_pkg::op_t op, logic [3:0] h, logic [7:0] din,
                              logic tend, int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {2'b00, din, h, op};
    s_tlast  <= tend;
    s_tvalid <= 1'b1;
    @(posedge clk iff s_tready);
    sent++;
  endtask

  // stop offering and wait until every outstanding result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  function automatic logic [3:0] pick_handle();
    if (open_handles.size() > 0 && $urandom_range(0, 9) != 0)
      return open_handles[$urandom_range(0, open_handles.size() - 1)];
    return 4'($urandom_range(0, 15));
  endfunction

  initial begin
    int gap;
    int r;
    htpf_pkg::op_t op;
    logic [3:0] h;
    repeat (5) @(posedge clk);
    rst <= 0;
    // directed: empty-slot errors, open, write/read extremes, full, wrong end, close
    send_request(htpf_pkg::OP_READ, 4'd15, 8'hff, 1'b1, 0);
    send_request(htpf_pkg::OP_WRITE, 4'd0, 8'h00, 1'b0, 0);
    send_request(htpf_pkg::OP_CLOSE, 4'd7, 8'h00, 1'b1, 0);
    send_request(htpf_pkg::OP_OPEN, 4'd0, 8'h00, 1'b0, 0);   // read end 0, write end 1
    send_request(htpf_pkg::OP_READ, 4'd0, 8'h00, 1'b0, 0);   // empty
    send_request(htpf_pkg::OP_WRITE, 4'd1, 8'hff, 1'b1, 0);
    send_request(htpf_pkg::OP_WRITE, 4'd1, 8'h00, 1'b0, 1);
    send_request(htpf_pkg::OP_WRITE, 4'd0, 8'h55, 1'b0, 0);  // write on read end
    send_request(htpf_pkg::OP_READ, 4'd1, 8'h00, 1'b0, 0);   // read on write end
    send_request(htpf_pkg::OP_READ, 4'd0, 8'h00, 1'b1, 0);
    send_request(htpf_pkg::OP_READ, 4'd0, 8'h00, 1'b0, 0);
    for (int i = 0; i < 66; i++)                // fill past capacity
      send_request(htpf_pkg::OP_WRITE, 4'd1, 8'(i * 37), i[0], 0);
    for (int i = 0; i < 8; i++)                 // exhaust handles
      send_request(htpf_pkg::OP_OPEN, 4'd0, 8'h00, 1'b0, 0);
    send_request(htpf_pkg::OP_CLOSE, 4'd1, 8'h00, 1'b0, 0);
    send_request(htpf_pkg::OP_READ, 4'd0, 8'h00, 1'b0, 0);
    send_request(htpf_pkg::OP_CLOSE, 4'd0, 8'h00, 1'b0, 0);
    send_request(htpf_pkg::OP_CLOSE, 4'd0, 8'h00, 1'b0, 0);
    for (int i = 2; i < 16; i++) send_request(htpf_pkg::OP_CLOSE, 4'(i), 8'h00, 1'b0, 0);
    drain();
    open_handles = {};
    // random: mostly writes/reads on live handles, with open/close churn
    while (sent < 700) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 11);
      if (stall_done && sent > 500 && sent < 510) gap = 0;
      r = $urandom_range(0, 99);
      if (r < 10) op = htpf_pkg::OP_OPEN;
      else if (r < 50) op = htpf_pkg::OP_WRITE;
      else if (r < 88) op = htpf_pkg::OP_READ;
      else op = htpf_pkg::OP_CLOSE;
      h = pick_handle();
      if (op == htpf_pkg::OP_OPEN) begin
        for (int i = 0; i < 16; i++) open_handles.push_back(4'(i));
        if (open_handles.size() > 16) open_handles = open_handles[0:15];
      end
      send_request(op, h, 8'($urandom), 1'($urandom), gap);
      if (sent == 600) drain();                 // sender pause until drained
    end
    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

/* filelist.f */
rtl/htpf_pkg.sv
rtl/htpf_byte_ram.sv
rtl/handle_table_pipe_fifos_core.sv
tb/sv/pipe_table_checker.sv
tb/sv/handle_table_pipe_fifos_core_tb.sv
